// ----- src/indexed_list_insert_delete_unit_macros.svh -----
// assertion helpers shared by the list unit
`ifndef INDEXED_LIST_INSERT_DELETE_UNIT_MACROS_SVH
`define INDEXED_LIST_INSERT_DELETE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ILID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ILID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ilid_pkg.sv -----
package ilid_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 16;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;
    localparam int LIST_LEN_W   = 7;

    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_HEAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_TAIL   = 3'd2;
    localparam logic [OP_W-1:0] OP_AT     = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic        [OP_W-1:0]   operation;
        logic signed [POS_W-1:0]  index;
        logic signed [DATA_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]     read_value;
        logic        [STATUS_W-1:0]   status;
        logic        [LIST_LEN_W-1:0] list_length;
    } result_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cmd_t;

endpackage

// ----- src/ilid_cell.sv -----
module ilid_cell #(
    parameter int IDX = 0
) (
    input  logic                         clk,
    input  ilid_pkg::cmd_t               cmd,
    input  logic [ilid_pkg::DATA_W-1:0]  left,
    input  logic [ilid_pkg::DATA_W-1:0]  right,
    output logic [ilid_pkg::DATA_W-1:0]  entry
);
    import ilid_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins)
        begin
            if (MY_POS == cmd.pos)
            begin
                entry_next = cmd.value;
            end
            else if (MY_POS > cmd.pos)
            begin
                entry_next = left;
            end
        end
        else if (cmd.del)
        begin
            if (MY_POS >= cmd.pos)
            begin
                entry_next = right;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- src/ilid_ctrl.sv -----
`include "indexed_list_insert_delete_unit_macros.svh"

module ilid_ctrl #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      item_valid,
    output logic                                      item_ready,
    input  ilid_pkg::item_t                           item,
    output logic                                      result_valid,
    input  logic                                      result_ready,
    output ilid_pkg::result_t                         result,
    input  logic [CAPACITY-1:0][ilid_pkg::DATA_W-1:0] entries,
    output ilid_pkg::cmd_t                            cmd
);
    import ilid_pkg::*;

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(CAPACITY);

    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    result_t           result_reg;
    result_t           result_next;
    logic              result_valid_reg;
    logic              accept;
    logic              in_list;
    logic              full;
    logic              do_ins;
    logic              do_del;
    logic [POS_W-1:0]  clamp_pos;
    logic [POS_W-1:0]  ins_pos;
    logic [POS_W:0]    pos_x;
    logic [POS_W:0]    len_x;
    logic [DATA_W-1:0] read_data;

    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    // negative index clamps to the head
    assign clamp_pos = item.index[POS_W-1] ? '0 : {1'b0, item.index[POS_W-2:0]};
    assign pos_x     = (POS_W + 1)'(clamp_pos);
    assign len_x     = (POS_W + 1)'(len_reg);
    assign in_list   = !item.index[POS_W-1] && (pos_x < len_x);
    assign full      = (len_reg == LEN_FULL);
    assign read_data = entries[item.index[IDX_W-1:0]];

    always_comb
    begin
        result_next             = '0;
        result_next.status      = ST_DONE;
        do_ins                  = 1'b0;
        do_del                  = 1'b0;
        ins_pos                 = '0;
        unique case (item.operation)
            OP_READ:
            begin
                if (in_list)
                begin
                    result_next.read_value = read_data;
                end
                else
                begin
                    result_next.read_value = '1;
                    result_next.status     = ST_INVALID;
                end
            end
            OP_HEAD:
            begin
                if (full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            OP_TAIL:
            begin
                ins_pos = POS_W'(len_reg);
                if (full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            OP_AT:
            begin
                ins_pos = clamp_pos;
                if (pos_x > len_x)
                begin
                    result_next.status = ST_INVALID;
                end
                else if (full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (in_list)
                begin
                    do_del = 1'b1;
                end
                else
                begin
                    result_next.status = ST_INVALID;
                end
            end
            default:
            begin
                result_next.status = ST_INVALID;
            end
        endcase

        len_next = len_reg;
        if (do_ins)
        begin
            len_next = len_reg + LEN_W'(1);
        end
        else if (do_del)
        begin
            len_next = len_reg - LEN_W'(1);
        end
        result_next.list_length = LIST_LEN_W'(len_next);
    end

    always_comb
    begin
        cmd.ins   = accept && do_ins;
        cmd.del   = accept && do_del;
        cmd.pos   = do_del ? clamp_pos : ins_pos;
        cmd.value = item.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                len_reg          <= len_next;
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ILID_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= LEN_FULL, "length past capacity")
    `ILID_ASSERT_NOW(a_one_shift, 1'b1, !(cmd.ins && cmd.del), "insert and delete together")
    `ILID_ASSERT_NEXT(a_beat_out, accept, result_valid, "accepted beat gave no result")
    `ILID_ASSERT_NEXT(a_len_hold, !accept, $stable(len_reg), "length moved without a beat")
    `ILID_ASSERT_NOW(a_full_drop, accept && result_next.status == ST_FULL, full && !cmd.ins,
        "full drop while space left")

endmodule

// ----- src/indexed_list_insert_delete_unit.sv -----
// a result is registered and valid in the cycle after its item beat is taken
// throughput: one item per cycle while results are taken, set by the result register
// every cell of the chain shifts in the same cycle on an insert or a delete
// reset clears the length and the result valid flag; cell contents are not cleared
module indexed_list_insert_delete_unit #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ilid_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output ilid_pkg::result_t result
);
    import ilid_pkg::*;

    cmd_t                          cmd;
    logic [CAPACITY-1:0][DATA_W-1:0] entries;

    ilid_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .entries      (entries),
        .cmd          (cmd)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;

        // the ends of the chain have no neighbour on one side
        if (i == 0)
        begin : g_head
            assign left = cmd.value;
        end
        else
        begin : g_mid_l
            assign left = entries[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right = entries[i];
        end
        else
        begin : g_mid_r
            assign right = entries[i+1];
        end

        ilid_cell #(
            .IDX (i)
        ) u_cell (
            .clk   (clk),
            .cmd   (cmd),
            .left  (left),
            .right (right),
            .entry (entries[i])
        );
    end

endmodule
